/* sv/clx_pkg.sv */
// Package for the C subset lexer: token types, kind and error codes,
// keyword and operator tables. No dependencies.
package clx_pkg;

  typedef enum logic [3:0] {
    M_IDLE, M_INT, M_IDENT, M_OP, M_LINE, M_BLOCK, M_STAR,
    M_CHOPEN, M_CHESC, M_CHCLOSE, M_STR, M_STRESC
  } scan_mode_t;

  localparam logic [2:0] K_END   = 3'd0;
  localparam logic [2:0] K_INT   = 3'd1;
  localparam logic [2:0] K_IDENT = 3'd2;
  localparam logic [2:0] K_STR   = 3'd3;
  localparam logic [2:0] K_PUNCT = 3'd4;
  localparam logic [2:0] K_OP2   = 3'd5;
  localparam logic [2:0] K_KWD   = 3'd6;
  localparam logic [2:0] K_ERR   = 3'd7;

  localparam logic [2:0] E_NONE    = 3'd0;
  localparam logic [2:0] E_UNKNOWN = 3'd1;
  localparam logic [2:0] E_QUOTE   = 3'd2;
  localparam logic [2:0] E_DQUOTE  = 3'd3;
  localparam logic [2:0] E_COMMENT = 3'd4;

  localparam int KW_SLOTS    = 30;
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  code;
    logic [63:0] int_value;
    logic [31:0] line_no;
    logic [31:0] col_no;
    logic [31:0] start_pos;
    logic [31:0] text_len;
    logic [2:0]  error_code;
    logic        last;
  } tok_t;

  // Up to two tokens written into the queue in one cycle.
  typedef struct packed {
    logic [1:0] n;
    tok_t       t0;
    tok_t       t1;
  } push_t;

  typedef struct packed {
    logic at_idle;
    logic halted;
  } front_stat_t;

  typedef struct packed {
    logic [2:0] count;
    logic       empty;
  } queue_stat_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic logic [3:0] kw_len(input logic [4:0] k);
    case (k)
      5'd0:  return 4'd6;  5'd1:  return 4'd3;  5'd2:  return 4'd5;
      5'd3:  return 4'd2;  5'd4:  return 4'd4;  5'd5:  return 4'd3;
      5'd6:  return 4'd4;  5'd7:  return 4'd4;  5'd8:  return 4'd5;
      5'd9:  return 4'd4;  5'd10: return 4'd8;  5'd11: return 4'd6;
      5'd12: return 4'd5;  5'd13: return 4'd8;  5'd14: return 4'd6;
      5'd15: return 4'd4;  5'd16: return 4'd6;  5'd17: return 4'd5;
      5'd18: return 4'd4;
      default: return 4'd0;
    endcase
  endfunction

  function automatic logic [63:0] kw_word(input logic [4:0] k);
    case (k)
      5'd0:  return 64'("return");   5'd1:  return 64'("for");
      5'd2:  return 64'("while");    5'd3:  return 64'("if");
      5'd4:  return 64'("else");     5'd5:  return 64'("int");
      5'd6:  return 64'("void");     5'd7:  return 64'("char");
      5'd8:  return 64'("short");    5'd9:  return 64'("long");
      5'd10: return 64'("unsigned"); 5'd11: return 64'("signed");
      5'd12: return 64'("break");    5'd13: return 64'("continue");
      5'd14: return 64'("sizeof");   5'd15: return 64'("long");
      5'd16: return 64'("struct");   5'd17: return 64'("union");
      5'd18: return 64'("enum");
      default: return 64'd0;
    endcase
  endfunction

  // Character i of keyword k, zero past its end.
  function automatic logic [7:0] kw_char(input logic [4:0] k, input logic [2:0] i);
    logic [3:0]  n;
    logic [63:0] w;
    logic [3:0]  sh;
    n  = kw_len(k);
    w  = kw_word(k);
    sh = n - 4'd1 - {1'b0, i};
    if ({1'b0, i} >= n) return 8'd0;
    return w[{sh[2:0], 3'b000} +: 8];
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {["0":"9"]};
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return c inside {["a":"z"], ["A":"Z"]};
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return c inside {"+", "-", "*", "/", "%", "(", ")", "=", ";", ",", "<", ">",
                     "{", "}", "&", "[", "]", "?", ":", ".", "!"};
  endfunction

  function automatic logic is_op_first(input logic [7:0] c);
    return c inside {"=", "!", "<", ">", "&", "|", "+", "-", "*", "/"};
  endfunction

  // Two-byte operator lookup: bit 4 is a hit, bits 3:0 the index.
  function automatic logic [4:0] op_index(input logic [7:0] f, input logic [7:0] c);
    case ({f, c})
      {"=", "="}: return 5'h10;
      {"!", "="}: return 5'h11;
      {"<", "="}: return 5'h12;
      {">", "="}: return 5'h13;
      {"&", "&"}: return 5'h14;
      {"|", "|"}: return 5'h15;
      {"+", "+"}: return 5'h16;
      {"-", "-"}: return 5'h17;
      {"+", "="}: return 5'h18;
      {"-", "="}: return 5'h19;
      {"*", "="}: return 5'h1A;
      {"/", "="}: return 5'h1B;
      {"-", ">"}: return 5'h1C;
      default:    return 5'h00;
    endcase
  endfunction

  function automatic logic [7:0] unescape(input logic [7:0] c);
    case (c)
      "n": return 8'd10;  "t": return 8'd9;  "r": return 8'd13;
      "v": return 8'd11;  "f": return 8'd12; "a": return 8'd7;
      "b": return 8'd8;
      default: return c;
    endcase
  endfunction

endpackage

/* sv/clx_front.sv */
// Scanner front end of the lexer: takes one byte, updates the scan state
// and produces up to two tokens. Depends on clx_pkg.
module clx_front #(
  parameter int POSITION_BITS = 32,
  parameter int NUM_KEYWORDS  = 19
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc,
  input  logic [7:0]          ch,
  output clx_pkg::push_t      push,
  output clx_pkg::front_stat_t stat
);
  import clx_pkg::*;

  localparam int P = POSITION_BITS;
  localparam int K = NUM_KEYWORDS;

  scan_mode_t    mode_r, mode_nxt;
  logic [31:0]   cur_line_r, cur_line_nxt, cur_col_r, cur_col_nxt;
  logic [P-1:0]  cur_pos_r, cur_pos_nxt, tok_start_r, tok_start_nxt;
  logic [31:0]   tok_line_r, tok_line_nxt, tok_col_r, tok_col_nxt;
  logic [31:0]   tok_len_r, tok_len_nxt;
  logic [63:0]   accum_r, accum_nxt;
  logic [K-1:0]  kw_mask_r, kw_mask_nxt;
  logic [7:0]    prev_r, prev_nxt;
  logic          halted_r, halted_nxt;

  function automatic logic [31:0] pos32(input logic [P-1:0] p);
    logic [63:0] w;
    w = 64'(p);
    return w[31:0];
  endfunction

  function automatic logic [K-1:0] kw_step(input logic [K-1:0] m,
                                           input logic [31:0] len,
                                           input logic [7:0] c);
    logic [K-1:0] r;
    r = m;
    for (int k = 0; k < K; k++) begin
      if (len >= 32'd8 || kw_char(5'(k), len[2:0]) != c) r[k] = 1'b0;
    end
    return r;
  endfunction

  function automatic tok_t mk(input logic [2:0] kind, input logic [7:0] code,
                              input logic [63:0] val, input logic [31:0] ln,
                              input logic [31:0] cl, input logic [31:0] ps,
                              input logic [31:0] len, input logic [2:0] err,
                              input logic last);
    tok_t t;
    t.kind = kind; t.code = code; t.int_value = val; t.line_no = ln;
    t.col_no = cl; t.start_pos = ps; t.text_len = len; t.error_code = err;
    t.last = last;
    return t;
  endfunction

  logic       a_v, b_v, redo, clr, kw_hit;
  tok_t       ta, tb;
  logic [4:0] opx, kw_idx;
  logic [31:0] end_line, end_col;

  always_comb begin
    mode_nxt = mode_r;       cur_line_nxt = cur_line_r; cur_col_nxt = cur_col_r;
    cur_pos_nxt = cur_pos_r; tok_start_nxt = tok_start_r;
    tok_line_nxt = tok_line_r; tok_col_nxt = tok_col_r; tok_len_nxt = tok_len_r;
    accum_nxt = accum_r;     kw_mask_nxt = kw_mask_r;  prev_nxt = prev_r;
    halted_nxt = halted_r;
    a_v = 1'b0; b_v = 1'b0; redo = 1'b0; clr = 1'b0;
    ta = '0; tb = '0;
    opx = op_index(prev_r, ch);
    kw_hit = 1'b0; kw_idx = '0;
    for (int k = K - 1; k >= 0; k--) begin
      if (kw_mask_r[k] && {28'd0, kw_len(5'(k))} == tok_len_r && kw_len(5'(k)) != 4'd0) begin
        kw_hit = 1'b1;
        kw_idx = 5'(k);
      end
    end
    end_line = 32'd0; end_col = 32'd0;

    // First pass: the byte against the current scan mode.
    if (halted_r) begin
      redo = 1'b1;
    end else begin
      case (mode_r)
        M_INT: begin
          if (is_digit(ch)) begin
            accum_nxt = (accum_r << 3) + (accum_r << 1) + 64'(ch - "0");
            cur_pos_nxt = cur_pos_r + 1'b1; prev_nxt = ch; cur_col_nxt = sat_inc(cur_col_r);
          end else begin
            a_v = 1'b1;
            ta = mk(K_INT, 8'd0, accum_r, tok_line_r, tok_col_r, pos32(tok_start_r),
                    32'd0, E_NONE, 1'b0);
            mode_nxt = M_IDLE; redo = 1'b1;
          end
        end
        M_IDENT: begin
          if (is_alpha(ch) || is_digit(ch) || ch == "_") begin
            kw_mask_nxt = kw_step(kw_mask_r, tok_len_r, ch);
            tok_len_nxt = sat_inc(tok_len_r);
            cur_pos_nxt = cur_pos_r + 1'b1; prev_nxt = ch; cur_col_nxt = sat_inc(cur_col_r);
          end else begin
            a_v = 1'b1;
            ta = mk(kw_hit ? K_KWD : K_IDENT, kw_hit ? {3'd0, kw_idx} : 8'd0, 64'd0,
                    tok_line_r, tok_col_r, pos32(tok_start_r), tok_len_r, E_NONE, 1'b0);
            mode_nxt = M_IDLE; redo = 1'b1;
          end
        end
        M_OP: begin
          if (prev_r == "/" && (ch == "/" || ch == "*")) begin
            mode_nxt = (ch == "/") ? M_LINE : M_BLOCK;
            cur_pos_nxt = cur_pos_r + 1'b1; prev_nxt = ch;
          end else if (opx[4]) begin
            a_v = 1'b1;
            ta = mk(K_OP2, {4'd0, opx[3:0]}, 64'd0, tok_line_r, tok_col_r,
                    pos32(tok_start_r), 32'd0, E_NONE, 1'b0);
            cur_col_nxt = sat_inc(sat_inc(cur_col_r));
            cur_pos_nxt = cur_pos_r + 1'b1; prev_nxt = ch; mode_nxt = M_IDLE;
          end else if (is_punct(prev_r)) begin
            a_v = 1'b1;
            ta = mk(K_PUNCT, prev_r, 64'd0, tok_line_r, tok_col_r, pos32(tok_start_r),
                    32'd0, E_NONE, 1'b0);
            cur_col_nxt = sat_inc(cur_col_r); mode_nxt = M_IDLE; redo = 1'b1;
          end else begin
            a_v = 1'b1;
            ta = mk(K_ERR, 8'd0, 64'd0, tok_line_r, tok_col_r, pos32(tok_start_r),
                    32'd0, E_UNKNOWN, 1'b0);
            halted_nxt = 1'b1; redo = 1'b1;
          end
        end
        M_LINE: begin
          if (ch == 8'h0A || ch == 8'h00) begin
            mode_nxt = M_IDLE; redo = 1'b1;
          end else begin
            cur_pos_nxt = cur_pos_r + 1'b1; prev_nxt = ch;
          end
        end
        M_BLOCK, M_STAR: begin
          if (ch == 8'h00) begin
            a_v = 1'b1;
            ta = mk(K_ERR, 8'd0, 64'd0, tok_line_r, tok_col_r, pos32(tok_start_r),
                    32'd0, E_COMMENT, 1'b0);
            halted_nxt = 1'b1; redo = 1'b1;
          end else begin
            if (mode_r == M_STAR && ch == "/") mode_nxt = M_IDLE;
            else if (ch == "*") mode_nxt = M_STAR;
            else begin
              mode_nxt = M_BLOCK;
              if (ch == 8'h0A) begin
                cur_line_nxt = sat_inc(cur_line_r); cur_col_nxt = 32'd1;
              end
            end
            cur_pos_nxt = cur_pos_r + 1'b1; prev_nxt = ch;
          end
        end
        M_CHOPEN, M_CHESC: begin
          if (ch == 8'h00) begin
            a_v = 1'b1;
            ta = mk(K_ERR, 8'd0, 64'd0, tok_line_r, tok_col_r, pos32(tok_start_r),
                    32'd0, E_QUOTE, 1'b0);
            halted_nxt = 1'b1; redo = 1'b1;
          end else begin
            if (mode_r == M_CHOPEN && ch == "\\") mode_nxt = M_CHESC;
            else begin
              accum_nxt = (mode_r == M_CHESC) ? 64'(signed'(unescape(ch)))
                                              : 64'(signed'(ch));
              mode_nxt = M_CHCLOSE;
            end
            cur_pos_nxt = cur_pos_r + 1'b1; prev_nxt = ch; cur_col_nxt = sat_inc(cur_col_r);
          end
        end
        M_CHCLOSE: begin
          if (ch != "'") begin
            a_v = 1'b1;
            ta = mk(K_ERR, 8'd0, 64'd0, tok_line_r, tok_col_r, pos32(tok_start_r),
                    32'd0, E_QUOTE, 1'b0);
            halted_nxt = 1'b1; redo = 1'b1;
          end else begin
            cur_pos_nxt = cur_pos_r + 1'b1; prev_nxt = ch; cur_col_nxt = sat_inc(cur_col_r);
            a_v = 1'b1;
            ta = mk(K_INT, 8'd0, accum_r, tok_line_r, tok_col_r, pos32(tok_start_r),
                    32'd0, E_NONE, 1'b0);
            mode_nxt = M_IDLE;
          end
        end
        M_STR, M_STRESC: begin
          if (ch == 8'h00) begin
            a_v = 1'b1;
            ta = mk(K_ERR, 8'd0, 64'd0, tok_line_r, tok_col_r, pos32(tok_start_r),
                    32'd0, E_DQUOTE, 1'b0);
            halted_nxt = 1'b1; redo = 1'b1;
          end else if (mode_r == M_STR && ch == "\"") begin
            cur_pos_nxt = cur_pos_r + 1'b1; prev_nxt = ch; cur_col_nxt = sat_inc(cur_col_r);
            a_v = 1'b1;
            ta = mk(K_STR, 8'd0, 64'd0, tok_line_r, tok_col_r, pos32(tok_start_r),
                    tok_len_r, E_NONE, 1'b0);
            mode_nxt = M_IDLE;
          end else begin
            mode_nxt = (mode_r == M_STR && ch == "\\") ? M_STRESC : M_STR;
            tok_len_nxt = sat_inc(tok_len_r);
            cur_pos_nxt = cur_pos_r + 1'b1; prev_nxt = ch; cur_col_nxt = sat_inc(cur_col_r);
          end
        end
        default: begin
          mode_nxt = M_IDLE; redo = 1'b1;
        end
      endcase
    end

    // Second pass: the byte seen from the idle mode, or the end of text.
    if (redo) begin
      end_line = cur_line_nxt; end_col = cur_col_nxt;
      if (prev_nxt == 8'h0A && cur_line_nxt != 32'd0) begin
        end_line = cur_line_nxt - 32'd1; end_col = 32'd1;
      end
      if (ch == 8'h00) begin
        b_v = 1'b1;
        tb = mk(K_END, 8'd0, 64'd0, end_line, end_col, pos32(cur_pos_nxt), 32'd0,
                E_NONE, 1'b1);
        clr = 1'b1;
      end else if (!halted_nxt) begin
        if (is_space(ch)) begin
          if (ch == 8'h0A) begin
            cur_line_nxt = sat_inc(cur_line_nxt); cur_col_nxt = 32'd1;
          end else cur_col_nxt = sat_inc(cur_col_nxt);
          cur_pos_nxt = cur_pos_nxt + 1'b1; prev_nxt = ch;
        end else begin
          tok_line_nxt = cur_line_nxt; tok_col_nxt = cur_col_nxt;
          tok_start_nxt = cur_pos_nxt;
          if (is_digit(ch)) begin
            accum_nxt = 64'(ch - "0"); mode_nxt = M_INT;
            cur_pos_nxt = cur_pos_nxt + 1'b1; prev_nxt = ch; cur_col_nxt = sat_inc(cur_col_nxt);
          end else if (ch == "'") begin
            mode_nxt = M_CHOPEN;
            cur_pos_nxt = cur_pos_nxt + 1'b1; prev_nxt = ch; cur_col_nxt = sat_inc(cur_col_nxt);
          end else if (ch == "\"") begin
            mode_nxt = M_STR; tok_len_nxt = 32'd0;
            cur_pos_nxt = cur_pos_nxt + 1'b1; prev_nxt = ch; cur_col_nxt = sat_inc(cur_col_nxt);
            tok_start_nxt = cur_pos_nxt;
          end else if (is_alpha(ch) || ch == "_") begin
            kw_mask_nxt = kw_step({K{1'b1}}, 32'd0, ch); tok_len_nxt = 32'd1;
            mode_nxt = M_IDENT;
            cur_pos_nxt = cur_pos_nxt + 1'b1; prev_nxt = ch; cur_col_nxt = sat_inc(cur_col_nxt);
          end else if (is_op_first(ch)) begin
            mode_nxt = M_OP; cur_pos_nxt = cur_pos_nxt + 1'b1; prev_nxt = ch;
          end else if (is_punct(ch)) begin
            b_v = 1'b1;
            tb = mk(K_PUNCT, ch, 64'd0, cur_line_nxt, cur_col_nxt, pos32(cur_pos_nxt),
                    32'd0, E_NONE, 1'b0);
            cur_pos_nxt = cur_pos_nxt + 1'b1; prev_nxt = ch; cur_col_nxt = sat_inc(cur_col_nxt);
          end else begin
            b_v = 1'b1;
            tb = mk(K_ERR, 8'd0, 64'd0, cur_line_nxt, cur_col_nxt, pos32(cur_pos_nxt),
                    32'd0, E_UNKNOWN, 1'b0);
            halted_nxt = 1'b1;
          end
        end
      end
    end

    if (clr) begin
      mode_nxt = M_IDLE; cur_line_nxt = 32'd1; cur_col_nxt = 32'd1; cur_pos_nxt = '0;
      tok_line_nxt = 32'd0; tok_col_nxt = 32'd0; tok_start_nxt = '0; tok_len_nxt = 32'd0;
      accum_nxt = 64'd0; kw_mask_nxt = {K{1'b1}}; prev_nxt = 8'd0; halted_nxt = 1'b0;
    end
  end

  always_comb begin
    push.n  = acc ? (2'(a_v) + 2'(b_v)) : 2'd0;
    push.t0 = a_v ? ta : tb;
    push.t1 = tb;
    stat.at_idle = (mode_r == M_IDLE);
    stat.halted  = halted_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE; cur_line_r <= 32'd1; cur_col_r <= 32'd1; cur_pos_r <= '0;
      tok_line_r <= 32'd0; tok_col_r <= 32'd0; tok_start_r <= '0; tok_len_r <= 32'd0;
      accum_r <= 64'd0; kw_mask_r <= {K{1'b1}}; prev_r <= 8'd0; halted_r <= 1'b0;
    end else if (acc) begin
      mode_r <= mode_nxt; cur_line_r <= cur_line_nxt; cur_col_r <= cur_col_nxt;
      cur_pos_r <= cur_pos_nxt; tok_line_r <= tok_line_nxt; tok_col_r <= tok_col_nxt;
      tok_start_r <= tok_start_nxt; tok_len_r <= tok_len_nxt; accum_r <= accum_nxt;
      kw_mask_r <= kw_mask_nxt; prev_r <= prev_nxt; halted_r <= halted_nxt;
    end
  end

endmodule

/* sv/clx_queue.sv */
// Token queue between scanner and output stage: two writes and one read
// per cycle. Depends on clx_pkg.
module clx_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  clx_pkg::push_t       push,
  input  logic                 pop,
  output clx_pkg::tok_t        head,
  output clx_pkg::queue_stat_t stat
);
  import clx_pkg::*;

  tok_t       mem_r [QUEUE_DEPTH];
  logic [1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [2:0] count_r, count_nxt;

  always_comb begin
    wr_nxt    = wr_r + push.n;
    rd_nxt    = rd_r + 2'(pop);
    count_nxt = count_r + 3'(push.n) - 3'(pop);
    head      = mem_r[rd_r];
    stat.count = count_r;
    stat.empty = (count_r == 3'd0);
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) mem_r[wr_r] <= push.t0;
    if (push.n == 2'd2) mem_r[wr_r + 2'd1] <= push.t1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= 2'd0; rd_r <= 2'd0; count_r <= 3'd0;
    end else begin
      wr_r <= wr_nxt; rd_r <= rd_nxt; count_r <= count_nxt;
    end
  end

endmodule

/* sv/clx_back.sv */
// Output stage of the lexer: holds one token in a register and packs it
// onto the result stream. Depends on clx_pkg.
module clx_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  clx_pkg::tok_t        head,
  input  clx_pkg::queue_stat_t qstat,
  output logic                 pop,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [207:0]         out_tdata,
  output logic [2:0]           out_tuser,
  output logic                 out_tlast
);
  import clx_pkg::*;

  logic out_valid_r, out_valid_nxt;
  tok_t tok_r;

  always_comb begin
    pop = !qstat.empty && (!out_valid_r || out_tready);
    out_valid_nxt = pop ? 1'b1 : (out_valid_r && !out_tready);
    out_tvalid = out_valid_r;
    out_tuser  = tok_r.kind;
    out_tlast  = tok_r.last;
    out_tdata  = {5'd0, tok_r.error_code, tok_r.text_len, tok_r.start_pos,
                  tok_r.col_no, tok_r.line_no, tok_r.int_value, tok_r.code};
  end

  always_ff @(posedge clk) begin
    if (pop) tok_r <= head;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= out_valid_nxt;
  end

endmodule

/* sv/c_subset_lexer_core.sv */
// C subset lexer top level: scanner front, token queue and output stage.
// Path: a token is written into the token queue, then held in the output register.
// Throughput: one byte per cycle while the queue holds at most two tokens; bytes that
// yield two tokens or a stalled output fill the queue, and the input stalls once
// more than two tokens wait in the queue.
// Reset: synchronous, active low; clears scan state, queue and output stage.
module c_subset_lexer_core #(
  parameter int POSITION_BITS = 32,
  parameter int NUM_KEYWORDS  = 19
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // ch[7:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  // code[7:0], int_value[71:8], line_no[103:72], col_no[135:104],
  // start_pos[167:136], text_len[199:168], error_code[202:200], zero pad
  output logic [207:0] out_tdata,
  output logic [2:0]   out_tuser,  // kind[2:0]
  output logic         out_tlast   // last
);
  import clx_pkg::*;

  push_t       push;
  front_stat_t fstat;
  queue_stat_t qstat;
  tok_t        head;
  logic        pop, acc;

  // A byte is taken only when the queue has room for both tokens it may make.
  assign in_tready = (qstat.count <= 3'(QUEUE_DEPTH - 2));
  assign acc = in_tvalid && in_tready;

  clx_front #(.POSITION_BITS(POSITION_BITS), .NUM_KEYWORDS(NUM_KEYWORDS)) u_front (
    .clk(clk), .rst_n(rst_n), .acc(acc), .ch(in_tdata), .push(push), .stat(fstat)
  );

  clx_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .pop(pop), .head(head), .stat(qstat)
  );

  clx_back u_back (
    .clk(clk), .rst_n(rst_n), .head(head), .qstat(qstat), .pop(pop),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  // The queue never holds more tokens than it has entries.
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qstat.count <= 3'(QUEUE_DEPTH)) else $error("token queue overflow");

  // The end-of-text byte returns the scanner to its reset state.
  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_tdata == 8'd0) |=> (fstat.at_idle && !fstat.halted))
    else $error("scanner not reset after end of text");

  // Popping the queue only happens when it holds a token.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !qstat.empty) else $error("pop from empty queue");

endmodule

/* tb/sv/c_subset_lexer_core_tb.sv */
// Self-checking testbench for the C subset lexer core.
// Drives source text bytes on the input stream and checks every token against
// a behavioral scanner model kept here. Depends on clx_pkg and c_subset_lexer_core.
`timescale 1ns / 1ps

module c_subset_lexer_core_tb;
  import clx_pkg::*;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [7:0]   in_tdata;   // ch[7:0]
  logic         out_tvalid;
  logic         out_tready;
  // code, int_value, line_no, col_no, start_pos, text_len, error_code, zero pad
  logic [207:0] out_tdata;
  logic [2:0]   out_tuser;  // kind[2:0]
  logic         out_tlast;  // last

  c_subset_lexer_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  localparam int STALL_LIMIT = 2000;

  // Scanner state mirrored from the block's behavior.
  scan_mode_t  sm;
  logic [31:0] ln, cl, ps, t_ln, t_cl, t_ps, t_len;
  logic [63:0] acc;
  logic [18:0] kmask;
  logic [7:0]  last_ch;
  bit          frozen;

  logic [7:0] src_bytes[$];
  tok_t       token_q[$];
  int         fail_cnt = 0;
  int         idle_cnt;
  bit         calm = 1'b0;
  int         in_gap, out_gap;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    fail_cnt++;
  endtask

  function automatic void scan_clear();
    sm = M_IDLE; ln = 32'd1; cl = 32'd1; ps = 32'd0;
    t_ln = 32'd0; t_cl = 32'd0; t_ps = 32'd0; t_len = 32'd0; acc = 64'd0;
    kmask = '1; last_ch = 8'd0; frozen = 1'b0;
  endfunction

  function automatic void push_tok(input logic [2:0] k, input logic [7:0] c,
                                   input logic [63:0] v, input logic [31:0] l,
                                   input logic [2:0] e);
    tok_t t;
    t.kind = k; t.code = c; t.int_value = v; t.line_no = t_ln; t.col_no = t_cl;
    t.start_pos = t_ps; t.text_len = l; t.error_code = e; t.last = 1'b0;
    token_q.push_back(t);
  endfunction

  function automatic void raise_error(input logic [2:0] e);
    push_tok(K_ERR, 8'd0, 64'd0, 32'd0, e);
    frozen = 1'b1;
  endfunction

  function automatic void close_text();
    tok_t t;
    t = '0;
    t.kind = K_END; t.line_no = ln; t.col_no = cl; t.start_pos = ps; t.last = 1'b1;
    if (last_ch == 8'd10 && ln > 32'd0) begin
      t.line_no = ln - 32'd1; t.col_no = 32'd1;
    end
    token_q.push_back(t);
    scan_clear();
  endfunction

  function automatic void take(input logic [7:0] c, input bit mv);
    ps = ps + 32'd1; last_ch = c;
    if (mv) cl = sat_inc(cl);
  endfunction

  function automatic logic [7:0] kw_char_at(input int k, input logic [31:0] i);
    string s;
    case (k)
      0: s = "return"; 1: s = "for"; 2: s = "while"; 3: s = "if"; 4: s = "else";
      5: s = "int"; 6: s = "void"; 7: s = "char"; 8: s = "short"; 9: s = "long";
      10: s = "unsigned"; 11: s = "signed"; 12: s = "break"; 13: s = "continue";
      14: s = "sizeof"; 15: s = "long"; 16: s = "struct"; 17: s = "union";
      default: s = "enum";
    endcase
    if (i >= s.len()) return 8'd0;
    return s[i];
  endfunction

  // Narrow the keyword candidates by the byte at position t_len.
  function automatic void narrow(input logic [7:0] c);
    for (int k = 0; k < 19; k++)
      if (kmask[k] && (t_len >= 32'd8 || kw_char_at(k, t_len) != c)) kmask[k] = 1'b0;
  endfunction

  function automatic int kw_hit();
    int n;
    for (int k = 0; k < 19; k++) begin
      if (!kmask[k]) continue;
      n = 0;
      while (n < 9 && kw_char_at(k, n) != 8'd0) n++;
      if (n == t_len && n > 0) return k;
    end
    return -1;
  endfunction

  function automatic logic [63:0] sx8(input logic [7:0] c);
    return {{56{c[7]}}, c};
  endfunction

  function automatic bit is_punct_byte(input logic [7:0] c);
    return c inside {"+", "-", "*", "/", "%", "(", ")", "=", ";", ",", "<", ">",
                     "{", "}", "&", "[", "]", "?", ":", ".", "!"};
  endfunction

  function automatic bit is_op_lead(input logic [7:0] c);
    return c inside {"=", "!", "<", ">", "&", "|", "+", "-", "*", "/"};
  endfunction

  function automatic logic [4:0] op_pair_idx(input logic [7:0] f, input logic [7:0] c);
    string pairs;
    pairs = "==!=<=>=&&||++--+=-=*=/=->";
    for (int i = 0; i < 13; i++)
      if (pairs[2*i] == f && pairs[2*i+1] == c) return {1'b1, i[3:0]};
    return 5'd0;
  endfunction

  function automatic logic [7:0] op_pair_idx_str(input int i, input int j);
    string pairs;
    pairs = "==!=<=>=&&||++--+=-=*=/=->";
    return pairs[2*i+j];
  endfunction

  function automatic logic [7:0] esc_value(input logic [7:0] c);
    case (c)
      "n": return 8'd10; "t": return 8'd9; "r": return 8'd13; "v": return 8'd11;
      "f": return 8'd12; "a": return 8'd7; "b": return 8'd8;
      default: return c;
    endcase
  endfunction

  // Returns 1 when the byte must be looked at again in the idle mode.
  function automatic bit scan_idle(input logic [7:0] c);
    if (c == 8'd0) begin
      close_text(); return 1'b0;
    end
    if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin
      if (c == 8'd10) begin
        ln = sat_inc(ln); cl = 32'd1;
      end else cl = sat_inc(cl);
      take(c, 1'b0);
      return 1'b0;
    end
    t_ln = ln; t_cl = cl; t_ps = ps;
    if (c >= "0" && c <= "9") begin
      acc = 64'(c - "0"); sm = M_INT; take(c, 1'b1);
    end else if (c == "'") begin
      sm = M_CHOPEN; take(c, 1'b1);
    end else if (c == "\"") begin
      sm = M_STR; t_len = 32'd0; take(c, 1'b1); t_ps = ps;
    end else if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_") begin
      kmask = '1; t_len = 32'd0; narrow(c); t_len = 32'd1; sm = M_IDENT; take(c, 1'b1);
    end else if (is_op_lead(c)) begin
      sm = M_OP; take(c, 1'b0);
    end else if (is_punct_byte(c)) begin
      push_tok(K_PUNCT, c, 64'd0, 32'd0, E_NONE); take(c, 1'b1);
    end else begin
      raise_error(E_UNKNOWN); return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit scan_byte(input logic [7:0] c);
    int k;
    logic [4:0] oi;
    case (sm)
      M_INT: begin
        if (c >= "0" && c <= "9") begin
          acc = acc * 64'd10 + 64'(c - "0"); take(c, 1'b1); return 1'b0;
        end
        push_tok(K_INT, 8'd0, acc, 32'd0, E_NONE); sm = M_IDLE; return 1'b1;
      end
      M_IDENT: begin
        if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
            (c >= "0" && c <= "9") || c == "_") begin
          narrow(c); t_len = sat_inc(t_len); take(c, 1'b1); return 1'b0;
        end
        k = kw_hit();
        if (k >= 0) push_tok(K_KWD, k[7:0], 64'd0, t_len, E_NONE);
        else push_tok(K_IDENT, 8'd0, 64'd0, t_len, E_NONE);
        sm = M_IDLE; return 1'b1;
      end
      M_OP: begin
        if (last_ch == "/" && c == "/") begin
          sm = M_LINE; take(c, 1'b0); return 1'b0;
        end
        if (last_ch == "/" && c == "*") begin
          sm = M_BLOCK; take(c, 1'b0); return 1'b0;
        end
        oi = op_pair_idx(last_ch, c);
        if (oi[4]) begin
          push_tok(K_OP2, {4'd0, oi[3:0]}, 64'd0, 32'd0, E_NONE);
          cl = sat_inc(sat_inc(cl)); take(c, 1'b0); sm = M_IDLE; return 1'b0;
        end
        if (is_punct_byte(last_ch)) begin
          push_tok(K_PUNCT, last_ch, 64'd0, 32'd0, E_NONE); cl = sat_inc(cl);
          sm = M_IDLE; return 1'b1;
        end
        raise_error(E_UNKNOWN); return 1'b1;
      end
      M_LINE: begin
        if (c == 8'd10 || c == 8'd0) begin
          sm = M_IDLE; return 1'b1;
        end
        take(c, 1'b0); return 1'b0;
      end
      M_BLOCK, M_STAR: begin
        if (c == 8'd0) begin
          raise_error(E_COMMENT); return 1'b1;
        end
        if (sm == M_STAR && c == "/") sm = M_IDLE;
        else if (c == "*") sm = M_STAR;
        else begin
          sm = M_BLOCK;
          if (c == 8'd10) begin
            ln = sat_inc(ln); cl = 32'd1;
          end
        end
        take(c, 1'b0); return 1'b0;
      end
      M_CHOPEN: begin
        if (c == 8'd0) begin
          raise_error(E_QUOTE); return 1'b1;
        end
        if (c == "\\") sm = M_CHESC;
        else begin
          acc = sx8(c); sm = M_CHCLOSE;
        end
        take(c, 1'b1); return 1'b0;
      end
      M_CHESC: begin
        if (c == 8'd0) begin
          raise_error(E_QUOTE); return 1'b1;
        end
        acc = sx8(esc_value(c)); sm = M_CHCLOSE; take(c, 1'b1); return 1'b0;
      end
      M_CHCLOSE: begin
        if (c != "'") begin
          raise_error(E_QUOTE); return 1'b1;
        end
        take(c, 1'b1); push_tok(K_INT, 8'd0, acc, 32'd0, E_NONE); sm = M_IDLE;
        return 1'b0;
      end
      M_STR, M_STRESC: begin
        if (c == 8'd0) begin
          raise_error(E_DQUOTE); return 1'b1;
        end
        if (sm == M_STR && c == "\"") begin
          take(c, 1'b1); push_tok(K_STR, 8'd0, 64'd0, t_len, E_NONE); sm = M_IDLE;
          return 1'b0;
        end
        sm = (sm == M_STR && c == "\\") ? M_STRESC : M_STR;
        t_len = sat_inc(t_len); take(c, 1'b1); return 1'b0;
      end
      default: begin
        sm = M_IDLE;
        return scan_idle(c);
      end
    endcase
  endfunction

  // Feeds one accepted byte into the model; a byte may be revisited.
  function automatic void predict_tokens(input logic [7:0] c);
    bit again;
    int guard;
    again = 1'b1; guard = 0;
    while (again && guard < 4) begin
      guard++;
      if (frozen) begin
        if (c == 8'd0) close_text();
        again = 1'b0;
      end else again = scan_byte(c);
    end
  endfunction

  // Stimulus text helpers.
  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) src_bytes.push_back(s[i]);
  endtask

  function automatic string pick_word();
    string w[$];
    w = '{"return", "for", "while", "if", "else", "int", "void", "char", "short",
          "long", "unsigned", "signed", "break", "continue", "sizeof", "struct",
          "union", "enum", "x", "_tmp9", "returns", "in", "lon", "Abc_Z"};
    return w[$urandom_range(0, w.size() - 1)];
  endfunction

  task automatic add_random_text();
    int n;
    string ops;
    logic [7:0] b;
    ops = "+-*/%()=;,<>{}&[]?:.!";
    n = $urandom_range(2, 14);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 11))
        0: add_text($sformatf("%0d", $urandom()));
        1: add_text(pick_word());
        2: add_text(" ");
        3: src_bytes.push_back(8'd10);
        4: src_bytes.push_back(ops[$urandom_range(0, ops.len() - 1)]);
        5: begin
          src_bytes.push_back(op_pair_idx_str($urandom_range(0, 12), 0));
          src_bytes.push_back(op_pair_idx_str($urandom_range(0, 12), 1));
        end
        6: begin
          add_text("'");
          if ($urandom_range(0, 2) == 0) add_text("\\");
          src_bytes.push_back(8'($urandom_range(1, 255)));
          add_text("'");
        end
        7: begin
          add_text("\"");
          repeat ($urandom_range(0, 5)) begin
            if ($urandom_range(0, 4) == 0) add_text("\\");
            b = 8'($urandom_range(32, 255));
            if (b == 8'h22) b = 8'h41;
            src_bytes.push_back(b);
          end
          add_text("\"");
        end
        8: begin
          if ($urandom_range(0, 1) == 1) add_text("/* c *\n* */");
          else add_text("// note\n");
        end
        9: src_bytes.push_back(8'($urandom_range(1, 255)));
        10: add_text("\t");
        default: add_text("18446744073709551617");
      endcase
    end
    // Sometimes end inside an open construct.
    case ($urandom_range(0, 9))
      0: add_text("\"ab");
      1: add_text("/* x");
      2: add_text("'");
      default: ;
    endcase
    src_bytes.push_back(8'd0);
  endtask

  initial begin
    // Directed texts: every token kind, all operators, escapes and each error.
    add_text("return for while if else int void char short long unsigned");
    add_text(" signed break continue sizeof struct union enum iff _a1\n");
    add_text("== != <= >= && || ++ -- += -= *= /= -> a+b;c-1 x|y");
    src_bytes.push_back(8'd0);
    add_text("18446744073709551616 0 '\\n' '\\t' 'q' '\\\\' \"\\\\\" \"a\nb\"");
    add_text(" /* one\n two */ // tail\n{}[]()?:.,!%~");
    src_bytes.push_back(8'd0);
    src_bytes.push_back(8'hFF); src_bytes.push_back(8'd0);
    add_text("'a"); src_bytes.push_back(8'd0);
    add_text("'"); src_bytes.push_back(8'd0);
    add_text("\"open"); src_bytes.push_back(8'd0);
    add_text("/* open"); src_bytes.push_back(8'd0);
    add_text("abc\n"); src_bytes.push_back(8'd0);
    src_bytes.push_back(8'd0);
    while (src_bytes.size() < 1850) add_random_text();
  end

  // Driver: one byte per handshake with random idle bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'd0;
      in_gap    <= 0;
      scan_clear();
    end else begin
      if (in_tvalid && in_tready) begin
        predict_tokens(in_tdata);
        void'(src_bytes.pop_front());
      end
      if ((in_tvalid && !in_tready)) begin
        // Hold the current item.
      end else if (in_gap > 0) begin
        in_gap    <= in_gap - 1;
        in_tvalid <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        in_gap    <= $urandom_range(0, 6);
        in_tvalid <= 1'b0;
      end else if (src_bytes.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tdata  <= src_bytes[0];
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: checks each accepted token against the oldest prediction.
  always @(posedge clk) begin
    tok_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_gap    <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (token_q.size() == 0) begin
          report("unexpected token", {61'd0, out_tuser}, 64'd0);
        end else begin
          want = token_q.pop_front();
          if (out_tuser != want.kind)
            report("kind", 64'(out_tuser), 64'(want.kind));
          if (out_tdata[7:0] != want.code)
            report("code", 64'(out_tdata[7:0]), 64'(want.code));
          if (out_tdata[71:8] != want.int_value)
            report("int_value", out_tdata[71:8], want.int_value);
          if (out_tdata[103:72] != want.line_no)
            report("line_no", 64'(out_tdata[103:72]), 64'(want.line_no));
          if (out_tdata[135:104] != want.col_no)
            report("col_no", 64'(out_tdata[135:104]), 64'(want.col_no));
          if (out_tdata[167:136] != want.start_pos)
            report("start_pos", 64'(out_tdata[167:136]), 64'(want.start_pos));
          if (out_tdata[199:168] != want.text_len)
            report("text_len", 64'(out_tdata[199:168]), 64'(want.text_len));
          if (out_tdata[202:200] != want.error_code)
            report("error_code", 64'(out_tdata[202:200]), 64'(want.error_code));
          if (out_tlast != want.last)
            report("last", 64'(out_tlast), 64'(want.last));
        end
      end
      if (out_gap > 0) begin
        out_gap    <= out_gap - 1;
        out_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_gap    <= $urandom_range(0, 6);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    wait (src_bytes.size() < 200);
    calm = 1'b1;
    wait (src_bytes.size() == 0);
    wait (token_q.size() == 0);
    repeat (20) @(posedge clk);
    if (fail_cnt == 0 && token_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/clx_pkg.sv
sv/clx_front.sv
sv/clx_queue.sv
sv/clx_back.sv
sv/c_subset_lexer_core.sv
tb/sv/c_subset_lexer_core_tb.sv
